### src/prr_pkg.sv
package prr_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;
  localparam int GUARD      = 16;

  // Datapath widths: the sign-extended coordinate, 16 guard bits, room for the
  // CORDIC gain of about 1.65 and for a rotated vector that is sqrt(2) longer
  localparam int EXT_W = COORD_BITS + 1;
  localparam int DP_W  = COORD_BITS + GUARD + 3;
  localparam int Z_W   = 35;
  localparam int A_W   = 14;
  localparam int MAG_W = 13;

  // Iteration count
  localparam int ITERATIONS     = 20;
  localparam int MAX_ITERATIONS = 32;

  // Angle units are 1/64 degree
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  // round(2^40 * pi / 11520): one angle unit in 2^-40 rad
  localparam logic [28:0] RAD_PER_UNIT = 29'd299845282;
  // CORDIC gain 0.60725293500888 in Q0.32
  localparam logic [31:0] GAIN_Q32     = 32'd2608131496;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [ANGLE_BITS-1:0] angle_deg;
  } req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic                         saturated;
  } rsp_t;

  // After angle reduction: angle folded into +-90 degrees, point negated if folded
  typedef struct packed {
    logic signed [EXT_W-1:0] x;
    logic signed [EXT_W-1:0] y;
    logic signed [A_W-1:0]   a;
  } prep_t;

  // CORDIC working vector and residual angle in 2^-32 rad
  typedef struct packed {
    logic signed [DP_W-1:0] x;
    logic signed [DP_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // round(atan(2^-i) * 2^32)
  function automatic logic [31:0] atan_q32(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd3373259426;
      1:  r = 32'd1991351318;
      2:  r = 32'd1052175346;
      3:  r = 32'd534100635;
      4:  r = 32'd268086748;
      5:  r = 32'd134174063;
      6:  r = 32'd67103403;
      7:  r = 32'd33553749;
      8:  r = 32'd16777131;
      9:  r = 32'd8388597;
      10: r = 32'd4194303;
      11: r = 32'd2097152;
      12: r = 32'd1048576;
      13: r = 32'd524288;
      14: r = 32'd262144;
      15: r = 32'd131072;
      16: r = 32'd65536;
      17: r = 32'd32768;
      18: r = 32'd16384;
      19: r = 32'd8192;
      20: r = 32'd4096;
      21: r = 32'd2048;
      22: r = 32'd1024;
      23: r = 32'd512;
      24: r = 32'd256;
      25: r = 32'd128;
      26: r = 32'd64;
      27: r = 32'd32;
      28: r = 32'd16;
      29: r = 32'd8;
      30: r = 32'd4;
      31: r = 32'd2;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### src/prr_prep.sv
module prr_prep (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prr_pkg::req_t req,
  output logic          out_valid,
  input  logic          out_ready,
  output prr_pkg::prep_t prep
);

  localparam logic [16:0] TURN1 = 17'(prr_pkg::FULL_TURN);
  localparam logic [16:0] TURN2 = 17'(2 * prr_pkg::FULL_TURN);
  localparam logic [16:0] TURN3 = 17'(3 * prr_pkg::FULL_TURN);

  logic [16:0]                     a_pos;
  logic [14:0]                     a_turn;
  logic signed [15:0]              a_half;
  logic                            flip;
  logic signed [prr_pkg::EXT_W-1:0] x_ext;
  logic signed [prr_pkg::EXT_W-1:0] y_ext;
  prr_pkg::prep_t                  prep_next;
  logic                            valid;

  always_comb begin
    // Shift into positive range, then reduce to [0, 360) degrees
    a_pos = 17'(req.angle_deg) + TURN2;
    if (a_pos >= TURN3) begin
      a_turn = 15'(a_pos - TURN3);
    end else if (a_pos >= TURN2) begin
      a_turn = 15'(a_pos - TURN2);
    end else if (a_pos >= TURN1) begin
      a_turn = 15'(a_pos - TURN1);
    end else begin
      a_turn = 15'(a_pos);
    end

    // Map to (-180, 180]
    a_half = $signed({1'b0, a_turn});
    if (a_turn > 15'(prr_pkg::HALF_TURN)) begin
      a_half = a_half - 16'(prr_pkg::FULL_TURN);
    end

    // Fold beyond +-90 degrees by negating the point
    flip  = (a_half > prr_pkg::QUARTER_TURN) || (a_half < -prr_pkg::QUARTER_TURN);
    x_ext = prr_pkg::EXT_W'(req.x_in);
    y_ext = prr_pkg::EXT_W'(req.y_in);

    prep_next.x = flip ? -x_ext : x_ext;
    prep_next.y = flip ? -y_ext : y_ext;
    if (a_half > prr_pkg::QUARTER_TURN) begin
      prep_next.a = prr_pkg::A_W'(a_half - 16'(prr_pkg::HALF_TURN));
    end else if (a_half < -prr_pkg::QUARTER_TURN) begin
      prep_next.a = prr_pkg::A_W'(a_half + 16'(prr_pkg::HALF_TURN));
    end else begin
      prep_next.a = prr_pkg::A_W'(a_half);
    end
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prep <= prep_next;
    end
  end

endmodule

### src/prr_scale.sv
module prr_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  prr_pkg::prep_t   prep,
  output logic             out_valid,
  input  logic             out_ready,
  output prr_pkg::cordic_t vec
);

  localparam int PW = prr_pkg::DP_W + prr_pkg::GUARD;

  localparam logic signed [32:0] GAIN = $signed({1'b0, prr_pkg::GAIN_Q32});

  logic [prr_pkg::MAG_W-1:0] mag;
  logic [41:0]               z_prod;
  logic [41:0]               z_rnd;
  logic [prr_pkg::Z_W-1:0]   z_abs;
  logic signed [PW-1:0]      x_prod;
  logic signed [PW-1:0]      y_prod;
  prr_pkg::cordic_t          vec_next;
  logic                      valid;

  always_comb begin
    // Degrees to radians, rounded to 2^-32 rad
    mag    = prep.a[prr_pkg::A_W-1] ? prr_pkg::MAG_W'(-prep.a) : prr_pkg::MAG_W'(prep.a);
    z_prod = 42'(mag) * 42'(prr_pkg::RAD_PER_UNIT);
    z_rnd  = z_prod + 42'd128;
    z_abs  = prr_pkg::Z_W'(z_rnd[41:8]);
    vec_next.z = prep.a[prr_pkg::A_W-1] ? $signed(-z_abs) : $signed(z_abs);

    // Pre-scale by the CORDIC gain, keep 16 guard bits (floored)
    x_prod = PW'(prep.x) * PW'(GAIN);
    y_prod = PW'(prep.y) * PW'(GAIN);
    vec_next.x = x_prod[PW-1:prr_pkg::GUARD];
    vec_next.y = y_prod[PW-1:prr_pkg::GUARD];
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vec <= vec_next;
    end
  end

endmodule

### src/prr_cordic_stage.sv
module prr_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  prr_pkg::cordic_t cur,
  output logic             out_valid,
  input  logic             out_ready,
  output prr_pkg::cordic_t nxt
);

  localparam logic signed [prr_pkg::Z_W-1:0] ATAN =
    $signed(prr_pkg::Z_W'(prr_pkg::atan_q32(SHIFT)));

  logic signed [prr_pkg::DP_W-1:0] dx;
  logic signed [prr_pkg::DP_W-1:0] dy;
  prr_pkg::cordic_t                nxt_next;
  logic                            valid;

  always_comb begin
    dx = cur.y >>> SHIFT;
    dy = cur.x >>> SHIFT;
    // Rotate toward zero residual angle
    if (!cur.z[prr_pkg::Z_W-1]) begin
      nxt_next.x = cur.x - dx;
      nxt_next.y = cur.y + dy;
      nxt_next.z = cur.z - ATAN;
    end else begin
      nxt_next.x = cur.x + dx;
      nxt_next.y = cur.y - dy;
      nxt_next.z = cur.z + ATAN;
    end
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      nxt <= nxt_next;
    end
  end

endmodule

### src/prr_round.sv
module prr_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  prr_pkg::cordic_t vec,
  output logic             out_valid,
  input  logic             out_ready,
  output prr_pkg::rsp_t    rsp
);

  localparam int RW = prr_pkg::DP_W - prr_pkg::GUARD;

  localparam logic signed [RW-1:0] HI = RW'((2 ** (prr_pkg::COORD_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] LO = -RW'(2 ** (prr_pkg::COORD_BITS - 1));
  localparam logic signed [prr_pkg::DP_W-1:0] HALF = prr_pkg::DP_W'(2 ** (prr_pkg::GUARD - 1));

  logic signed [prr_pkg::DP_W-1:0] x_sum;
  logic signed [prr_pkg::DP_W-1:0] y_sum;
  logic signed [RW-1:0]            x_rnd;
  logic signed [RW-1:0]            y_rnd;
  logic                            x_sat;
  logic                            y_sat;
  prr_pkg::rsp_t                   rsp_next;
  logic                            valid;

  always_comb begin
    // Round half up, drop guard bits
    x_sum = vec.x + HALF;
    y_sum = vec.y + HALF;
    x_rnd = x_sum[prr_pkg::DP_W-1:prr_pkg::GUARD];
    y_rnd = y_sum[prr_pkg::DP_W-1:prr_pkg::GUARD];

    x_sat = (x_rnd > HI) || (x_rnd < LO);
    y_sat = (y_rnd > HI) || (y_rnd < LO);

    if (x_rnd > HI) begin
      rsp_next.x_out = HI[prr_pkg::COORD_BITS-1:0];
    end else if (x_rnd < LO) begin
      rsp_next.x_out = LO[prr_pkg::COORD_BITS-1:0];
    end else begin
      rsp_next.x_out = x_rnd[prr_pkg::COORD_BITS-1:0];
    end

    if (y_rnd > HI) begin
      rsp_next.y_out = HI[prr_pkg::COORD_BITS-1:0];
    end else if (y_rnd < LO) begin
      rsp_next.y_out = LO[prr_pkg::COORD_BITS-1:0];
    end else begin
      rsp_next.y_out = y_rnd[prr_pkg::COORD_BITS-1:0];
    end

    rsp_next.saturated = x_sat | y_sat;
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

### src/point_rotation_2d.sv
// Channel   Handshake               Payload       Carries
// request   req_valid / req_ready   req (req_t)   x_in, y_in (Q15.8), angle_deg (1/64 deg)
// result    rsp_valid / rsp_ready   rsp (rsp_t)   x_out, y_out (Q15.8), saturated
//
// Stages in order: angle reduction, radian and gain multiply, one stage per CORDIC
// iteration, then round and clip. One request per cycle while rsp_ready is high.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage takes a new request whenever it is empty or its successor moves,
// so a stalled result holds only the stages behind it that are full.
module point_rotation_2d #(
  parameter int ITERATIONS = prr_pkg::ITERATIONS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  prr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output prr_pkg::rsp_t rsp
);

  // Prep stage: reduce the angle to +-90 degrees, negate the point if folded
  prr_pkg::prep_t prep;
  logic           prep_valid;
  logic           prep_ready;

  // CORDIC chain: index 0 leaves the scale stage, index ITERATIONS the last stage
  prr_pkg::cordic_t vec   [ITERATIONS+1];
  logic             valid [ITERATIONS+1];
  logic             ready [ITERATIONS+1];

  logic round_ready;

  prr_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .req       (req),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .prep      (prep)
  );

  // Convert to radians and apply the gain up front
  prr_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .prep      (prep),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .vec       (vec[0])
  );

  // One micro-rotation per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    prr_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .cur       (vec[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .nxt       (vec[i+1])
    );
  end

  assign ready[ITERATIONS] = round_ready;

  // Drop guard bits and clip into the coordinate range
  prr_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[ITERATIONS]),
    .in_ready  (round_ready),
    .vec       (vec[ITERATIONS]),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .rsp       (rsp)
  );

  localparam logic signed [prr_pkg::COORD_BITS-1:0] CMAX =
    prr_pkg::COORD_BITS'((2 ** (prr_pkg::COORD_BITS - 1)) - 1);
  localparam logic signed [prr_pkg::COORD_BITS-1:0] CMIN = ~CMAX;

  // A ready consumer never stalls the pipeline
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    rsp_ready |-> req_ready)
    else $error("request stalled while result side is ready");

  // Stall on the request side only when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("request stalled without a pending result");

  // Saturation puts at least one coordinate on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.saturated) |->
      (rsp.x_out == CMAX || rsp.x_out == CMIN || rsp.y_out == CMAX || rsp.y_out == CMIN))
    else $error("saturated flag without clipped coordinate");

endmodule
